[rtl/core/lje_pkg.sv]
// ----------------------------------------------------------------------------
// lje_pkg
// Shared types and constants for the Lennard-Jones pair energy unit.
// ----------------------------------------------------------------------------
package lje_pkg;

    localparam int DIST_W   = 24;
    localparam int SIGMA_W  = 24;
    localparam int EPS_W    = 32;
    localparam int ENERGY_W = 64;
    localparam int INDEX_W  = 8;

    localparam logic [INDEX_W-1:0] REG_WELL_DEPTH = 8'd0;
    localparam logic [INDEX_W-1:0] REG_SIGMA      = 8'd1;

    localparam logic [EPS_W-1:0]   WELL_DEPTH_RESET = 32'd44379897;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET      = 24'd223150;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ENERGY_W-1:0] ENERGY_MIN = 64'h8000_0000_0000_0000;

    // classification made at the front, carried alongside the data
    typedef struct packed {
        logic zero;     // distance is zero
        logic big;      // sigma/r >= 64, energy out of range
        logic eps_nz;   // well depth nonzero
    } lje_tag_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        lje_tag_t          tag;
    } lje_item_t;

endpackage

[rtl/core/lje_front.sv]
// ----------------------------------------------------------------------------
// lje_front
// Accepts distances and classifies them before they enter the queue.
// ----------------------------------------------------------------------------
module lje_front
    import lje_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               queue_full,
    input  logic [DIST_W-1:0]  distance,
    input  logic [SIGMA_W-1:0] sigma,
    input  logic [EPS_W-1:0]   well_depth,
    output logic               push,
    output lje_item_t          item
);

    logic      push_reg;
    lje_item_t item_reg;
    lje_item_t item_next;
    logic      accept;

    assign accept = start && !queue_full;

    always_comb
    begin
        item_next.distance   = distance;
        item_next.tag.zero   = (distance == '0);
        // q >= 2^38 exactly when sigma >= 64*r
        item_next.tag.big    = ({6'd0, sigma} >= {distance, 6'd0});
        item_next.tag.eps_nz = (well_depth != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_reg <= 1'b0;
        end
        else
        begin
            push_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign push = push_reg;
    assign item = item_reg;

endmodule

[rtl/core/lje_queue.sv]
// ----------------------------------------------------------------------------
// lje_queue
// Two-entry queue between front and back; the back drains it every cycle.
// ----------------------------------------------------------------------------
module lje_queue
    import lje_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lje_item_t push_item,
    output logic      full,
    output logic      pop_valid,
    output lje_item_t pop_item
);

    lje_item_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    logic       pop_valid_reg;
    lje_item_t  pop_item_reg;

    assign pop  = (count_reg != 2'd0);
    assign full = (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
            pop_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg     <= count_next;
            pop_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
        if (pop)
        begin
            pop_item_reg <= mem[rd_ptr_reg];
        end
    end

    assign pop_valid = pop_valid_reg;
    assign pop_item  = pop_item_reg;

endmodule

[rtl/core/lje_mul.sv]
// ----------------------------------------------------------------------------
// lje_mul
// Two-stage unsigned multiplier built from registered 32x32 partial products.
// ----------------------------------------------------------------------------
module lje_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int PW = (NA + NB) * 32;

    logic [NA*32-1:0]  a_pad;
    logic [NB*32-1:0]  b_pad;
    logic [63:0]       pp_reg [NA][NB];
    logic [PW-1:0]     sum;
    logic [AW+BW-1:0]  p_reg;

    assign a_pad = (NA*32)'(a);
    assign b_pad = (NB*32)'(b);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= 64'(a_pad[32*i +: 32]) * 64'(b_pad[32*j +: 32]);
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum = sum + (PW'(pp_reg[i][j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= sum[AW+BW-1:0];
    end

    assign p = p_reg;

endmodule

[rtl/core/lje_back.sv]
// ----------------------------------------------------------------------------
// lje_back
// Pipelined restoring divider for sigma/r, power chain, energy and clamping.
// ----------------------------------------------------------------------------
module lje_back
    import lje_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  lje_item_t           in_item,
    input  logic [SIGMA_W-1:0]  sigma,
    input  logic [EPS_W-1:0]    well_depth,
    output logic                out_valid,
    output logic [ENERGY_W-1:0] energy,
    output logic                saturated,
    output logic                zero_distance
);

    localparam int QW  = 38;   // quotient bits, s < 64 with 32 fraction bits
    localparam int LAT = 54;   // stages from queue output to the final select

    // tag pipeline
    logic     valid_pipe_reg [LAT];
    lje_tag_t tag_pipe_reg   [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                valid_pipe_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_pipe_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                valid_pipe_reg[i] <= valid_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_pipe_reg[0] <= in_item.tag;
        for (int i = 1; i < LAT; i++)
        begin
            tag_pipe_reg[i] <= tag_pipe_reg[i-1];
        end
    end

    // divider: one quotient bit per stage
    logic [DIST_W-1:0] div_rem_reg [QW];
    logic [DIST_W-1:0] div_r_reg   [QW];
    logic [QW-1:0]     div_q_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [DIST_W-1:0] rem_in;
        logic [DIST_W-1:0] r_in;
        logic [QW-1:0]     q_in;
        logic              nbit;
        logic [DIST_W:0]   trial;
        logic              ge;
        logic [DIST_W:0]   diff;

        if (k == 0)
        begin : g_first
            // high part of sigma*2^32 above the quotient window
            assign rem_in = {6'd0, sigma[SIGMA_W-1:6]};
            assign r_in   = in_item.distance;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = div_rem_reg[k-1];
            assign r_in   = div_r_reg[k-1];
            assign q_in   = div_q_reg[k-1];
        end

        if (k <= 5)
        begin : g_sbit
            assign nbit = sigma[5-k];
        end
        else
        begin : g_zbit
            assign nbit = 1'b0;
        end

        assign trial = {rem_in, nbit};
        assign ge    = (trial >= {1'b0, r_in});
        assign diff  = trial - {1'b0, r_in};

        always_ff @(posedge clk)
        begin
            div_rem_reg[k] <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
            div_r_reg[k]   <= r_in;
            div_q_reg[k]   <= {q_in[QW-2:0], ge};
        end
    end

    logic [QW-1:0] q;
    assign q = div_q_reg[QW-1];

    // s2 = q*q
    logic [75:0]  p2;
    logic [43:0]  s2_reg;
    logic [75:0]  p2r;
    lje_mul #(.AW(38), .BW(38)) u_mul_s2 (.clk(clk), .a(q), .b(q), .p(p2));
    assign p2r = p2 + 76'h8000_0000;

    logic [QW-1:0] q_dly_reg [3];

    always_ff @(posedge clk)
    begin
        s2_reg       <= p2r[75:32];
        q_dly_reg[0] <= q;
        q_dly_reg[1] <= q_dly_reg[0];
        q_dly_reg[2] <= q_dly_reg[1];
    end

    // s3 = s2*q
    logic [81:0] p3;
    logic [81:0] p3r;
    logic [49:0] s3_reg;
    lje_mul #(.AW(44), .BW(38)) u_mul_s3 (.clk(clk), .a(s2_reg), .b(q_dly_reg[2]),
                                          .p(p3));
    assign p3r = p3 + 82'h8000_0000;

    always_ff @(posedge clk)
    begin
        s3_reg <= p3r[81:32];
    end

    // s6 = s3*s3
    logic [99:0] p6;
    logic [99:0] p6r;
    logic [67:0] s6_reg;
    lje_mul #(.AW(50), .BW(50)) u_mul_s6 (.clk(clk), .a(s3_reg), .b(s3_reg), .p(p6));
    assign p6r = p6 + 100'h8000_0000;

    logic [67:0] s6_dly_reg [3];

    always_ff @(posedge clk)
    begin
        s6_reg        <= p6r[99:32];
        s6_dly_reg[0] <= s6_reg;
        s6_dly_reg[1] <= s6_dly_reg[0];
        s6_dly_reg[2] <= s6_dly_reg[1];
    end

    // s12 = s6*s6
    logic [135:0] p12;
    logic [135:0] p12r;
    logic [103:0] s12_reg;
    lje_mul #(.AW(68), .BW(68)) u_mul_s12 (.clk(clk), .a(s6_reg), .b(s6_reg),
                                           .p(p12));
    assign p12r = p12 + 136'h8000_0000;

    always_ff @(posedge clk)
    begin
        s12_reg <= p12r[135:32];
    end

    // d = |s12 - s6|
    logic [103:0] s6_ext;
    logic [103:0] d_reg;
    logic         neg_reg;
    logic         neg_dly_reg [3];

    assign s6_ext = 104'(s6_dly_reg[2]);

    always_ff @(posedge clk)
    begin
        neg_reg        <= (s12_reg < s6_ext);
        d_reg          <= (s12_reg < s6_ext) ? (s6_ext - s12_reg) : (s12_reg - s6_ext);
        neg_dly_reg[0] <= neg_reg;
        neg_dly_reg[1] <= neg_dly_reg[0];
        neg_dly_reg[2] <= neg_dly_reg[1];
    end

    // m = round(eps*d / 2^30)
    logic [135:0] pe;
    logic [135:0] per;
    logic [105:0] m_reg;
    lje_mul #(.AW(104), .BW(32)) u_mul_e (.clk(clk), .a(d_reg), .b(well_depth),
                                          .p(pe));
    assign per = pe + 136'h2000_0000;

    always_ff @(posedge clk)
    begin
        m_reg <= per[135:30];
    end

    // final select and clamp
    lje_tag_t            tag;
    logic                neg;
    logic [ENERGY_W-1:0] energy_next;
    logic                sat_next;
    logic [ENERGY_W-1:0] energy_reg;
    logic                sat_reg;
    logic                zero_reg;
    logic                out_valid_reg;

    assign tag = tag_pipe_reg[LAT-1];
    assign neg = neg_dly_reg[2];

    always_comb
    begin
        energy_next = '0;
        sat_next    = 1'b0;
        if (tag.zero)
        begin
            energy_next = ENERGY_MAX;
            sat_next    = 1'b1;
        end
        else if (tag.big)
        begin
            energy_next = tag.eps_nz ? ENERGY_MAX : '0;
            sat_next    = tag.eps_nz;
        end
        else if (!neg)
        begin
            if (m_reg[105:63] != '0)
            begin
                energy_next = ENERGY_MAX;
                sat_next    = 1'b1;
            end
            else
            begin
                energy_next = {1'b0, m_reg[62:0]};
            end
        end
        else
        begin
            if (m_reg[105:63] != '0)
            begin
                energy_next = ENERGY_MIN;
                sat_next    = (m_reg[105:64] != '0);
            end
            else
            begin
                energy_next = '0 - {1'b0, m_reg[62:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_pipe_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        sat_reg    <= sat_next;
        zero_reg   <= tag.zero;
    end

    assign out_valid     = out_valid_reg;
    assign energy        = energy_reg;
    assign saturated     = sat_reg;
    assign zero_distance = zero_reg;

endmodule

[rtl/core/lennard_jones_pair_energy_unit.sv]
// Accepted distances pass the front register, queue and back-end pipeline.
// Throughput: one distance per cycle, sustained; set by the one-bit-per-stage
//   divider and the pipelined multipliers, which never stall.
// Results cannot be held off; done pulses for one cycle per transaction.
// Reset: rst_n asynchronous, active low; clears all valid state and loads
//   the argon-argon well depth and sigma.
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy_unit
// Lennard-Jones 12-6 pair energy in fixed point, one distance per cycle.
// ----------------------------------------------------------------------------
module lennard_jones_pair_energy_unit
    import lje_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [DIST_W-1:0]   distance,
    output logic                done,
    output logic [ENERGY_W-1:0] energy,
    output logic                saturated,
    output logic                zero_distance,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [EPS_W-1:0]   well_depth_reg;
    logic [SIGMA_W-1:0] sigma_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            well_depth_reg <= WELL_DEPTH_RESET;
            sigma_reg      <= SIGMA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WELL_DEPTH: well_depth_reg <= cfg_data;
                REG_SIGMA:      sigma_reg      <= cfg_data[SIGMA_W-1:0];
                default:        ;
            endcase
        end
    end

    logic      push;
    lje_item_t push_item;
    logic      queue_full;
    logic      pop_valid;
    lje_item_t pop_item;

    lje_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .queue_full (queue_full),
        .distance   (distance),
        .sigma      (sigma_reg),
        .well_depth (well_depth_reg),
        .push       (push),
        .item       (push_item)
    );

    lje_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    lje_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pop_valid),
        .in_item       (pop_item),
        .sigma         (sigma_reg),
        .well_depth    (well_depth_reg),
        .out_valid     (done),
        .energy        (energy),
        .saturated     (saturated),
        .zero_distance (zero_distance)
    );

    assign busy = queue_full;

    // the back end drains one item per cycle, so the queue never fills
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("queue filled up");

    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_distance |-> saturated && energy == ENERGY_MAX)
        else $error("zero distance not clamped");

    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated && !energy[ENERGY_W-1] |-> energy == ENERGY_MAX)
        else $error("positive clamp value wrong");

    a_zero_in: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && distance == '0 |=> u_front.item.tag.zero)
        else $error("zero distance not classified");

endmodule

[tb/sv/lennard_jones_pair_energy_checker.sv]
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy_checker
// Watches the distance, result and register channels of the pair energy
// unit, predicts each energy from its own copy of eps and sigma, and
// compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module lennard_jones_pair_energy_checker
    import lje_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [DIST_W-1:0]   distance,
    input  logic                done,
    input  logic [ENERGY_W-1:0] energy,
    input  logic                saturated,
    input  logic                zero_distance,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  mismatches,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                saturated;
        logic                zero_distance;
    } pair_energy_t;

    logic [EPS_W-1:0]   eps_copy;
    logic [SIGMA_W-1:0] sigma_copy;
    pair_energy_t       energy_queue[$];

    // round half up of p / 2^k
    function automatic logic [255:0] round_shift(logic [255:0] p, int k);
        return (p + (256'd1 << (k - 1))) >> k;
    endfunction

    function automatic pair_energy_t pair_energy(logic [DIST_W-1:0] r);
        pair_energy_t res;
        logic [55:0]  num;
        logic [255:0] q, s2, s3, s6, s12, d, m;
        logic         neg;
        res = '0;
        if (r == '0) begin
            res.energy = ENERGY_MAX;
            res.saturated = 1'b1;
            res.zero_distance = 1'b1;
            return res;
        end
        num = {sigma_copy, 32'd0};
        q = 256'(num / 56'(r));
        if (q >= (256'd1 << 38)) begin
            if (eps_copy != '0) begin
                res.energy = ENERGY_MAX;
                res.saturated = 1'b1;
            end
            return res;
        end
        s2  = round_shift(q * q, 32);
        s3  = round_shift(s2 * q, 32);
        s6  = round_shift(s3 * s3, 32);
        s12 = round_shift(s6 * s6, 32);
        neg = s12 < s6;
        d   = neg ? s6 - s12 : s12 - s6;
        m   = round_shift(d * 256'(eps_copy), 30);
        if (!neg) begin
            if (m >= (256'd1 << 63)) begin
                res.energy = ENERGY_MAX;
                res.saturated = 1'b1;
            end else begin
                res.energy = m[63:0];
            end
        end else if (m >= (256'd1 << 63)) begin
            res.energy = ENERGY_MIN;
            res.saturated = m >= (256'd1 << 64);
        end else begin
            res.energy = 64'd0 - m[63:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pair_energy_t exp_res;
        int           errs;
        if (!rst_n) begin
            eps_copy <= WELL_DEPTH_RESET;
            sigma_copy <= SIGMA_RESET;
            energy_queue.delete();
            mismatches <= 0;
            pending <= 0;
        end else begin
            errs = 0;
            if (done) begin
                if (energy_queue.size() == 0) begin
                    $error("result with nothing expected: energy %h", energy);
                    errs++;
                end else begin
                    exp_res = energy_queue.pop_front();
                    if (energy !== exp_res.energy) begin
                        $error("energy: expected %h actual %h", exp_res.energy, energy);
                        errs++;
                    end
                    if (saturated !== exp_res.saturated) begin
                        $error("saturated: expected %b actual %b",
                               exp_res.saturated, saturated);
                        errs++;
                    end
                    if (zero_distance !== exp_res.zero_distance) begin
                        $error("zero_distance: expected %b actual %b",
                               exp_res.zero_distance, zero_distance);
                        errs++;
                    end
                end
            end
            // registers must only change while idle (the unit does not enforce it), so predicting here is safe
            if (start && !busy)
                energy_queue.push_back(pair_energy(distance));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WELL_DEPTH)
                    eps_copy <= cfg_data;
                else if (cfg_index == REG_SIGMA)
                    sigma_copy <= cfg_data[SIGMA_W-1:0];
            end
            mismatches <= mismatches + errs;
            pending <= energy_queue.size();
        end
    end

endmodule

[tb/sv/lennard_jones_pair_energy_unit_test.sv]
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy_unit_test
// Drives distances in random bursts through several eps/sigma settings
// (reset values, species pairs, zeros and extremes); the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module lennard_jones_pair_energy_unit_test;
    import lje_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam logic [INDEX_W-1:0] REG_UNUSED = 8'd2;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [DIST_W-1:0]   distance = '0;
    logic                cfg_valid = 1'b0;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [31:0]         cfg_data = '0;
    logic                busy, done, saturated, zero_distance, cfg_ready;
    logic [ENERGY_W-1:0] energy;
    int                  mismatches, pending;
    int                  idle_cycles = 0;
    logic [SIGMA_W-1:0]  cur_sigma = SIGMA_RESET;
    logic [EPS_W-1:0]    phase_eps[PHASES];
    logic [SIGMA_W-1:0]  phase_sigma[PHASES];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lennard_jones_pair_energy_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .distance(distance),
        .done(done), .energy(energy), .saturated(saturated),
        .zero_distance(zero_distance), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lennard_jones_pair_energy_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .distance(distance),
        .done(done), .energy(energy), .saturated(saturated),
        .zero_distance(zero_distance), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // leaves start high; the caller lowers it at the end of a burst
    task automatic send_distance(logic [DIST_W-1:0] r);
        start <= 1'b1;
        distance <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic end_burst();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        int unsigned lo, hi;
        lo = cur_sigma * 3 / 4;
        hi = cur_sigma * 3;
        if (hi > 24'hFFFFFF)
            hi = 24'hFFFFFF;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return DIST_W'($urandom_range(lo, hi));
            6: return DIST_W'($urandom);
            7: return DIST_W'($urandom_range(0, cur_sigma / 32 + 2));
            8: return DIST_W'($urandom_range(0, 255));
            default: return $urandom_range(0, 1) ? '0 : 24'hFFFFFF;
        endcase
    endfunction

    task automatic run_items(int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) send_distance(pick_distance());
            left -= burst;
            end_burst();
        end
        start <= 1'b0;
    endtask

    task automatic drain(int extra);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    initial
    begin
        logic [DIST_W-1:0] directed[$];
        phase_eps   = '{WELL_DEPTH_RESET, 32'hFFFFFFFF, 32'd0, 32'd12906000,
                        32'd3753800, 32'd1, 32'hFFFFFFFF, 32'd0};
        phase_sigma = '{SIGMA_RESET, 24'hFFFFFF, 24'd223150, 24'd195363,
                        24'd167510, 24'd0, 24'd1, 24'hFFFFFF};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero, tiny, full scale, r = sigma, near the minimum,
        // around the ratio-of-64 boundary, single bits, alternating bits
        directed = '{24'd0, 24'd1, 24'hFFFFFF, SIGMA_RESET, 24'd250468,
                     24'd3486, 24'd3487, 24'd3488, 24'd3485, 24'd200000,
                     24'h800000, 24'h010000, 24'h000100, 24'h555555, 24'hAAAAAA};
        foreach (directed[i]) begin
            send_distance(directed[i]);
            if (i % 5 == 4)
                end_burst();
        end
        start <= 1'b0;
        run_items(ITEMS_PER_PHASE - directed.size());
        drain(DRAIN_CYCLES);

        for (int p = 1; p < PHASES; p++) begin
            write_reg(REG_WELL_DEPTH, phase_eps[p]);
            write_reg(REG_SIGMA, 32'(phase_sigma[p]) | 32'hAB000000);
            if (p == 3)
                write_reg(REG_UNUSED, $urandom);
            cur_sigma = phase_sigma[p];
            send_distance('0);
            send_distance(24'hFFFFFF);
            send_distance(cur_sigma == '0 ? 24'd1 : cur_sigma);
            start <= 1'b0;
            run_items(ITEMS_PER_PHASE);
            drain(DRAIN_CYCLES);
        end

        // random registers in a physical sigma band
        for (int p = 0; p < 2; p++) begin
            write_reg(REG_WELL_DEPTH, $urandom);
            cur_sigma = SIGMA_W'($urandom_range(98304, 327680));
            write_reg(REG_SIGMA, 32'(cur_sigma));
            run_items(40);
            drain(DRAIN_CYCLES);
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
